// ===== hdl/pqadc_pkg.sv =====
`timescale 1ns / 1ps
// Shared types, codes and helper functions for the PQ ADC distance scorer.
// No dependencies; the scorer and the tables refer to this package.
package pqadc_pkg;

  localparam int SUM_W = 48;
  localparam logic [SUM_W-1:0] SUM_MAX = {SUM_W{1'b1}};

  // Request kinds carried on the input tuser.
  localparam logic [1:0] CMD_TABLE = 2'd0;
  localparam logic [1:0] CMD_STEP  = 2'd1;
  localparam logic [1:0] CMD_CODE  = 2'd2;

  // Configuration register indexes.
  localparam logic REG_NUM_SUB  = 1'b0;
  localparam logic REG_RES_BITS = 1'b1;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_PQ_RD,
    ST_PQ_TERM,
    ST_FIELD,
    ST_MAG,
    ST_SQ,
    ST_LO,
    ST_HI,
    ST_TERM,
    ST_ACC,
    ST_STEP
  } state_t;

  typedef struct packed {
    logic dist_we;
    logic step_we;
  } tbl_wr_t;

  function automatic logic [3:0] eff_bits(input logic [3:0] raw);
    return (raw > 4'd8) ? 4'd8 : raw;
  endfunction

  // log2 of the number of residual fields packed in one byte.
  function automatic logic [1:0] fields_shift(input logic [3:0] bits);
    logic [1:0] sh;
    unique case (bits)
      4'd1:       sh = 2'd3;
      4'd2:       sh = 2'd2;
      4'd3, 4'd4: sh = 2'd1;
      default:    sh = 2'd0;
    endcase
    return sh;
  endfunction

endpackage

// ===== hdl/pq_adc_distance_scorer.sv =====
`timescale 1ns / 1ps
// Channel  Dir  tdata                                            tuser
// in_      in   sub_index, codeword_index, entry_value, code_byte cmd
// out_     out  distance                                         saturated
// cfg_     in   index 0 num_subspaces, index 1 residual_bits (write only)
// A table or step write is taken while the sequencer is idle. A PQ byte passes through
// the registered table read and the saturating adder. A residual byte visits its fields
// one by one; a nonzero field goes to the one shared multiplier, which forms mag^2, step^2
// and two partial products in turn, and a zero-magnitude field skips it.
// Reset is synchronous, active low; it restores the configuration registers and clears the sequencer.
// A finished sum waits in the output register; only the next code end stalls on it.
module pq_adc_distance_scorer #(
  parameter int MAX_SUBSPACES = 16,
  parameter int MAX_CODEWORDS = 256
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [55:0] in_tdata,   // sub_index, codeword_index, entry_value, code_byte
  input  logic [1:0]  in_tuser,   // cmd
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [47:0] out_tdata,  // distance
  output logic [0:0]  out_tuser,  // saturated
  input  logic        cfg_we,
  input  logic [0:0]  cfg_index,
  input  logic [4:0]  cfg_wdata
);

  localparam int SUB_W = (MAX_SUBSPACES > 1) ? $clog2(MAX_SUBSPACES) : 1;
  localparam int CW_W  = $clog2(MAX_CODEWORDS);
  localparam int M_CAP = (MAX_SUBSPACES > 31) ? 31 : MAX_SUBSPACES;
  localparam logic [4:0] M_CAP_V  = 5'(M_CAP);
  localparam logic [6:0] SUB_LIM  = 7'(MAX_SUBSPACES);
  localparam logic [8:0] CW_LIM   = 9'(MAX_CODEWORDS);
  localparam logic [5:0] POS_LAST = 6'd61;

  logic [3:0]  in_sub;
  logic [7:0]  in_cw;
  logic [31:0] in_val;
  logic [7:0]  in_byte;

  assign in_sub  = in_tdata[3:0];
  assign in_cw   = in_tdata[11:4];
  assign in_val  = in_tdata[43:12];
  assign in_byte = in_tdata[51:44];

  logic [4:0] num_sub_r;
  logic [3:0] res_bits_r;

  localparam logic [0:0] REG_NUM_SUB_IDX  = pqadc_pkg::REG_NUM_SUB;
  localparam logic [0:0] REG_RES_BITS_IDX = pqadc_pkg::REG_RES_BITS;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      num_sub_r  <= 5'd16;
      res_bits_r <= 4'd1;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_NUM_SUB_IDX:  num_sub_r  <= cfg_wdata;
        REG_RES_BITS_IDX: res_bits_r <= cfg_wdata[3:0];
      endcase
    end
  end

  logic [4:0] m;
  logic [3:0] bits;
  logic [1:0] sh;
  logic [3:0] per_byte;
  logic [5:0] res_bytes;
  logic [5:0] len;
  logic [7:0] mag_mask;

  assign m         = (num_sub_r == 5'd0) ? 5'd1 :
                     ((num_sub_r > M_CAP_V) ? M_CAP_V : num_sub_r);
  assign bits      = pqadc_pkg::eff_bits(res_bits_r);
  assign sh        = pqadc_pkg::fields_shift(bits);
  assign per_byte  = 4'd1 << sh;
  assign res_bytes = (bits == 4'd0) ? 6'd0 :
                     (({1'b0, m} + {2'b0, per_byte} - 6'd1) >> sh);
  assign len       = {1'b0, m} + res_bytes;
  assign mag_mask  = (8'd1 << (bits - 4'd1)) - 8'd1;

  pqadc_pkg::state_t state_r, state_nxt;
  logic [5:0]  pos_r, pos_nxt;
  logic [7:0]  byte_r, byte_nxt;
  logic [8:0]  s_r, s_nxt;
  logic [3:0]  f_r, f_nxt;
  logic [13:0] m2_r, m2_nxt;
  logic [63:0] s2_r, s2_nxt;
  logic [45:0] lo_r, lo_nxt;
  logic [47:0] term_r, term_nxt;
  logic [47:0] run_r, run_nxt;
  logic        clip_r, clip_nxt;
  logic        out_valid_r, out_valid_nxt;
  logic [47:0] out_dist_r, out_dist_nxt;
  logic        out_sat_r, out_sat_nxt;

  pqadc_pkg::tbl_wr_t tbl_wr;
  logic [31:0] dist_rdata;
  logic [31:0] step_rdata;
  logic [31:0] mul_a, mul_b;
  logic [63:0] mul_p;

  logic        in_pq;
  logic        sub_ok;
  logic        cw_wr_ok;
  logic        cw_rd_ok;
  logic [7:0]  mag;
  logic [5:0]  r_idx;
  logic [62:0] term_wide;
  logic [48:0] sum_wide;
  logic [6:0]  sub_ext;

  assign in_pq     = pos_r < {1'b0, m};
  assign sub_ext   = {3'b0, in_sub};
  assign sub_ok    = sub_ext < SUB_LIM;
  assign cw_wr_ok  = {1'b0, in_cw} < CW_LIM;
  assign cw_rd_ok  = {1'b0, byte_r} < CW_LIM;
  assign mag       = byte_r & mag_mask;
  assign r_idx     = pos_r - {1'b0, m};
  assign term_wide = {1'b0, mul_p[45:0], 16'b0} + {33'b0, lo_r[45:16]};
  assign sum_wide  = {1'b0, run_r} + {1'b0, term_r};

  pqadc_tables #(
    .SUB_W(SUB_W),
    .CW_W (CW_W)
  ) u_tables (
    .clk         (clk),
    .wr          (tbl_wr),
    .wr_sub      (sub_ext[SUB_W-1:0]),
    .wr_cw       (in_cw[CW_W-1:0]),
    .wr_data     (in_val),
    .dist_raddr  ({pos_r[SUB_W-1:0], byte_r[CW_W-1:0]}),
    .step_raddr  (s_r[SUB_W-1:0]),
    .dist_rdata_r(dist_rdata),
    .step_rdata_r(step_rdata)
  );

  pqadc_mul u_mul (
    .clk(clk),
    .a  (mul_a),
    .b  (mul_b),
    .p_r(mul_p)
  );

  assign in_tready  = (state_r == pqadc_pkg::ST_IDLE);
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_dist_r;
  assign out_tuser  = out_sat_r;

  always_comb begin
    state_nxt     = state_r;
    pos_nxt       = pos_r;
    byte_nxt      = byte_r;
    s_nxt         = s_r;
    f_nxt         = f_r;
    m2_nxt        = m2_r;
    s2_nxt        = s2_r;
    lo_nxt        = lo_r;
    term_nxt      = term_r;
    run_nxt       = run_r;
    clip_nxt      = clip_r;
    out_valid_nxt = out_valid_r && !out_tready;
    out_dist_nxt  = out_dist_r;
    out_sat_nxt   = out_sat_r;
    tbl_wr        = '0;
    mul_a         = 32'd0;
    mul_b         = 32'd0;
    unique case (state_r)
      pqadc_pkg::ST_IDLE: begin
        if (in_tvalid) begin
          unique case (in_tuser)
            pqadc_pkg::CMD_TABLE: tbl_wr.dist_we = sub_ok && cw_wr_ok;
            pqadc_pkg::CMD_STEP:  tbl_wr.step_we = sub_ok;
            pqadc_pkg::CMD_CODE: begin
              byte_nxt = in_byte;
              if (in_pq) begin
                state_nxt = pqadc_pkg::ST_PQ_RD;
              end else if (bits == 4'd0) begin
                state_nxt = pqadc_pkg::ST_STEP;
              end else begin
                s_nxt     = {3'b0, r_idx} << sh;
                f_nxt     = 4'd0;
                state_nxt = pqadc_pkg::ST_FIELD;
              end
            end
            default: ;
          endcase
        end
      end
      pqadc_pkg::ST_PQ_RD: begin
        state_nxt = pqadc_pkg::ST_PQ_TERM;
      end
      pqadc_pkg::ST_PQ_TERM: begin
        term_nxt  = cw_rd_ok ? {16'b0, dist_rdata} : 48'd0;
        state_nxt = pqadc_pkg::ST_ACC;
      end
      pqadc_pkg::ST_FIELD: begin
        if (f_r == per_byte || s_r >= {4'b0, m}) begin
          state_nxt = pqadc_pkg::ST_STEP;
        end else if (mag == 8'd0) begin
          byte_nxt = byte_r >> bits;
          f_nxt    = f_r + 4'd1;
          s_nxt    = s_r + 9'd1;
        end else begin
          state_nxt = pqadc_pkg::ST_MAG;
        end
      end
      pqadc_pkg::ST_MAG: begin
        mul_a     = {24'b0, mag};
        mul_b     = {24'b0, mag};
        state_nxt = pqadc_pkg::ST_SQ;
      end
      pqadc_pkg::ST_SQ: begin
        m2_nxt    = mul_p[13:0];
        mul_a     = step_rdata;
        mul_b     = step_rdata;
        state_nxt = pqadc_pkg::ST_LO;
      end
      pqadc_pkg::ST_LO: begin
        s2_nxt    = mul_p;
        mul_a     = {18'b0, m2_r};
        mul_b     = mul_p[31:0];
        state_nxt = pqadc_pkg::ST_HI;
      end
      pqadc_pkg::ST_HI: begin
        lo_nxt    = mul_p[45:0];
        mul_a     = {18'b0, m2_r};
        mul_b     = s2_r[63:32];
        state_nxt = pqadc_pkg::ST_TERM;
      end
      pqadc_pkg::ST_TERM: begin
        term_nxt  = (|term_wide[62:48]) ? pqadc_pkg::SUM_MAX : term_wide[47:0];
        state_nxt = pqadc_pkg::ST_ACC;
      end
      pqadc_pkg::ST_ACC: begin
        if (sum_wide[48]) begin
          run_nxt  = pqadc_pkg::SUM_MAX;
          clip_nxt = 1'b1;
        end else begin
          run_nxt = sum_wide[47:0];
        end
        if (in_pq) begin
          state_nxt = pqadc_pkg::ST_STEP;
        end else begin
          byte_nxt  = byte_r >> bits;
          f_nxt     = f_r + 4'd1;
          s_nxt     = s_r + 9'd1;
          state_nxt = pqadc_pkg::ST_FIELD;
        end
      end
      pqadc_pkg::ST_STEP: begin
        if (pos_r + 6'd1 >= len) begin
          if (!out_valid_r || out_tready) begin
            out_valid_nxt = 1'b1;
            out_dist_nxt  = run_r;
            out_sat_nxt   = clip_r;
            run_nxt       = 48'd0;
            clip_nxt      = 1'b0;
            pos_nxt       = 6'd0;
            state_nxt     = pqadc_pkg::ST_IDLE;
          end
        end else begin
          pos_nxt   = pos_r + 6'd1;
          state_nxt = pqadc_pkg::ST_IDLE;
        end
      end
      default: state_nxt = pqadc_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= pqadc_pkg::ST_IDLE;
      pos_r       <= 6'd0;
      run_r       <= 48'd0;
      clip_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      pos_r       <= pos_nxt;
      run_r       <= run_nxt;
      clip_r      <= clip_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    byte_r     <= byte_nxt;
    s_r        <= s_nxt;
    f_r        <= f_nxt;
    m2_r       <= m2_nxt;
    s2_r       <= s2_nxt;
    lo_r       <= lo_nxt;
    term_r     <= term_nxt;
    out_dist_r <= out_dist_nxt;
    out_sat_r  <= out_sat_nxt;
  end

`ifndef ASSERT_OFF
  a_clip_holds_max: assert property (@(posedge clk) disable iff (!rst_n)
    clip_r |-> run_r == pqadc_pkg::SUM_MAX)
    else $error("clip flag set while the running sum is below its maximum");

  a_pos_bounded: assert property (@(posedge clk) disable iff (!rst_n)
    pos_r <= POS_LAST)
    else $error("byte position beyond the longest code");

  a_result_from_step: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r) == pqadc_pkg::ST_STEP)
    else $error("result raised outside the code end step");

  a_state_cleared: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> run_r == 48'd0 && !clip_r && pos_r == 6'd0)
    else $error("code state not cleared when its result was loaded");

  a_field_count: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == pqadc_pkg::ST_MAG |-> f_r < per_byte && mag != 8'd0)
    else $error("multiply started for an empty or missing field");
`endif

endmodule

// ===== hdl/pqadc_mul.sv =====
`timescale 1ns / 1ps
// Shared 32 x 32 unsigned multiplier with a registered product.
// Used by the scorer sequencer for every square and partial product.
module pqadc_mul (
  input  logic        clk,
  input  logic [31:0] a,
  input  logic [31:0] b,
  output logic [63:0] p_r
);

  logic [63:0] p_nxt;

  assign p_nxt = {32'b0, a} * {32'b0, b};

  always_ff @(posedge clk) begin
    p_r <= p_nxt;
  end

endmodule

// ===== hdl/pqadc_tables.sv =====
`timescale 1ns / 1ps
// Distance table and residual step memories with registered reads.
// Depends on pqadc_pkg for the write request struct.
module pqadc_tables #(
  parameter int SUB_W = 4,
  parameter int CW_W  = 8
) (
  input  logic                    clk,
  input  pqadc_pkg::tbl_wr_t      wr,
  input  logic [SUB_W-1:0]        wr_sub,
  input  logic [CW_W-1:0]         wr_cw,
  input  logic [31:0]             wr_data,
  input  logic [SUB_W+CW_W-1:0]   dist_raddr,
  input  logic [SUB_W-1:0]        step_raddr,
  output logic [31:0]             dist_rdata_r,
  output logic [31:0]             step_rdata_r
);

  localparam int DIST_DEPTH = 1 << (SUB_W + CW_W);
  localparam int STEP_DEPTH = 1 << SUB_W;

  logic [31:0] dist_mem [DIST_DEPTH];
  logic [31:0] step_mem [STEP_DEPTH];

  always_ff @(posedge clk) begin
    if (wr.dist_we) begin
      dist_mem[{wr_sub, wr_cw}] <= wr_data;
    end
    dist_rdata_r <= dist_mem[dist_raddr];
  end

  always_ff @(posedge clk) begin
    if (wr.step_we) begin
      step_mem[wr_sub] <= wr_data;
    end
    step_rdata_r <= step_mem[step_raddr];
  end

endmodule
